>>> src/fmtg_pkg.sv
// Shared types, constants and elaboration-time table builders for the FM tone generator.
// Holds the microcode program, note decode and quarter-wave sine evaluation.
// Depends on nothing; used by fm_tone_generator.
package fmtg_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned SAMPLE_RATE_DEF    = 44100;
  localparam int unsigned SINE_ADDR_BITS_DEF = 10;
  localparam int unsigned PHASE_BITS_DEF     = 32;

  // Configuration register widths and reset values
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned AMP_W     = 15;
  localparam int unsigned MIDX_W    = 16;
  localparam int unsigned RATIO_W   = 4;
  localparam logic [AMP_W-1:0]   AMP_RESET   = 15'd8000;
  localparam logic [MIDX_W-1:0]  MIDX_RESET  = 16'd40960;
  localparam logic [RATIO_W-1:0] RATIO_RESET = 4'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AMPLITUDE = 2'd0,
    REG_MOD_INDEX = 2'd1,
    REG_MOD_RATIO = 2'd2
  } cfg_reg_e;

  // Datapath widths and fixed-point constants
  localparam int unsigned MUL_W    = 32;
  localparam int unsigned PROD_W   = 64;
  localparam int unsigned SINE_W   = 15;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned Q_W      = 16;
  localparam int unsigned DIVP_W   = 30;
  localparam int unsigned REM_W    = 31;
  localparam int unsigned TURN_Q   = 59;
  localparam logic [63:0] PI_HALF_Q30     = 64'd1686629713;
  localparam logic [MUL_W-1:0] INV_TWO_PI_Q32 = 32'd683565276;
  localparam logic [SINE_W-1:0] SINE_PEAK = 15'd32767;
  localparam logic [63:0] ONE_HALF_Q30    = 64'd536870912;
  localparam int unsigned DIV_K_SHIFT = 15;

  // Note decode
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_G = 8'h67;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_G = 8'h47;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_6 = 8'h36;
  localparam logic [1:0] OCT_LOW  = 2'd0;
  localparam logic [1:0] OCT_MID  = 2'd1;
  localparam logic [1:0] OCT_HIGH = 2'd2;
  localparam int unsigned NUM_OCT  = 3;
  localparam int unsigned NUM_SEMI = 12;
  localparam int unsigned FREQ_W   = 23;

  // Lowest octave note frequencies in Q16 Hz
  localparam logic [FREQ_W-1:0] BASE_FREQ_Q16 [NUM_SEMI] = '{
    23'd3604480, 23'd3818814, 23'd4045892, 23'd4286473, 23'd4541360, 23'd4811404,
    23'd5097505, 23'd5400618, 23'd5721755, 23'd6061989, 23'd6422453, 23'd6804352
  };

  typedef struct packed {
    logic       rest;
    logic [1:0] oct;
    logic [3:0] semi;
  } note_t;

  function automatic logic [3:0] letter_semi(logic [2:0] li);
    logic [3:0] s;
    unique case (li)
      3'd0:    s = 4'd0;
      3'd1:    s = 4'd2;
      3'd2:    s = 4'd3;
      3'd3:    s = 4'd5;
      3'd4:    s = 4'd7;
      3'd5:    s = 4'd8;
      3'd6:    s = 4'd10;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

  function automatic note_t decode_note(logic [7:0] code);
    note_t      n;
    logic [2:0] li;
    n  = '0;
    li = 3'd0;
    if (code >= CHAR_LOWER_A && code <= CHAR_LOWER_G) begin
      li    = 3'(code - CHAR_LOWER_A);
      n.oct = OCT_MID;
    end else if (code >= CHAR_UPPER_A && code <= CHAR_UPPER_G) begin
      li    = 3'(code - CHAR_UPPER_A);
      n.oct = OCT_HIGH;
    end else if (code >= CHAR_DIGIT_0 && code <= CHAR_DIGIT_6) begin
      li    = 3'(code - CHAR_DIGIT_0);
      n.oct = OCT_LOW;
    end else begin
      n.rest = 1'b1;
    end
    n.semi = letter_semi(li);
    return n;
  endfunction

  // Taylor term divisors (2n)(2n+1)
  function automatic logic [63:0] taylor_div(int n, logic [63:0] t);
    logic [63:0] r;
    unique case (n)
      1:       r = t / 6;
      2:       r = t / 20;
      3:       r = t / 42;
      4:       r = t / 72;
      default: r = t / 110;
    endcase
    return r;
  endfunction

  // Quarter-wave sine entry, Q30 Taylor series scaled to a 32767 peak.
  // Only evaluated at elaboration to build the ROM contents.
  function automatic logic [SINE_W-1:0] quarter_sine(logic [63:0] r, int unsigned addr_bits);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] sum;
    logic [63:0] v;
    x    = (r * PI_HALF_Q30) >> (addr_bits - 2);
    term = x;
    pos  = x;
    neg  = 64'd0;
    for (int n = 1; n <= 5; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = taylor_div(n, term);
      if ((n % 2) == 1) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    sum = (pos > neg) ? pos - neg : 64'd0;
    v   = (sum * 64'(SINE_PEAK) + ONE_HALF_Q30) >> 30;
    if (v > 64'(SINE_PEAK)) begin
      v = 64'(SINE_PEAK);
    end
    return SINE_W'(v);
  endfunction

  // Microcode
  localparam int unsigned STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_IDLE    = 4'd0;
  localparam logic [STEP_W-1:0] STEP_CARRIER = 4'd1;
  localparam logic [STEP_W-1:0] STEP_MODPH   = 4'd2;
  localparam logic [STEP_W-1:0] STEP_ROM_MOD = 4'd3;
  localparam logic [STEP_W-1:0] STEP_IDX     = 4'd4;
  localparam logic [STEP_W-1:0] STEP_INV     = 4'd5;
  localparam logic [STEP_W-1:0] STEP_ROUND   = 4'd6;
  localparam logic [STEP_W-1:0] STEP_TOTAL   = 4'd7;
  localparam logic [STEP_W-1:0] STEP_ROM_TOT = 4'd8;
  localparam logic [STEP_W-1:0] STEP_AMP     = 4'd9;
  localparam logic [STEP_W-1:0] STEP_DIV     = 4'd10;
  localparam logic [STEP_W-1:0] STEP_EMIT    = 4'd11;
  localparam logic [STEP_W-1:0] STEP_LAST    = STEP_EMIT;

  typedef enum logic [3:0] {
    OP_ACCEPT      = 4'd0,
    OP_MUL_CARRIER = 4'd1,
    OP_MUL_MOD     = 4'd2,
    OP_ROM_MOD     = 4'd3,
    OP_MUL_IDX     = 4'd4,
    OP_MUL_INV     = 4'd5,
    OP_ROUND       = 4'd6,
    OP_ADD_OFF     = 4'd7,
    OP_ROM_TOT     = 4'd8,
    OP_MUL_AMP     = 4'd9,
    OP_DIV_EST     = 4'd10,
    OP_EMIT        = 4'd11
  } uop_e;

  typedef enum logic [1:0] {
    COND_NONE     = 2'd0,
    COND_IN_WAIT  = 2'd1,
    COND_REST     = 2'd2,
    COND_OUT_WAIT = 2'd3
  } cond_e;

  typedef struct packed {
    uop_e              op;
    cond_e             cond;
    logic [STEP_W-1:0] target;
  } uword_t;

  function automatic uword_t mk_uword(uop_e op, cond_e cond, logic [STEP_W-1:0] target);
    uword_t w;
    w.op     = op;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  // Program: one control word per step
  function automatic uword_t ucode(logic [STEP_W-1:0] step);
    uword_t w;
    unique case (step)
      STEP_IDLE:    w = mk_uword(OP_ACCEPT,      COND_IN_WAIT,  STEP_IDLE);
      STEP_CARRIER: w = mk_uword(OP_MUL_CARRIER, COND_REST,     STEP_EMIT);
      STEP_MODPH:   w = mk_uword(OP_MUL_MOD,     COND_NONE,     STEP_IDLE);
      STEP_ROM_MOD: w = mk_uword(OP_ROM_MOD,     COND_NONE,     STEP_IDLE);
      STEP_IDX:     w = mk_uword(OP_MUL_IDX,     COND_NONE,     STEP_IDLE);
      STEP_INV:     w = mk_uword(OP_MUL_INV,     COND_NONE,     STEP_IDLE);
      STEP_ROUND:   w = mk_uword(OP_ROUND,       COND_NONE,     STEP_IDLE);
      STEP_TOTAL:   w = mk_uword(OP_ADD_OFF,     COND_NONE,     STEP_IDLE);
      STEP_ROM_TOT: w = mk_uword(OP_ROM_TOT,     COND_NONE,     STEP_IDLE);
      STEP_AMP:     w = mk_uword(OP_MUL_AMP,     COND_NONE,     STEP_IDLE);
      STEP_DIV:     w = mk_uword(OP_DIV_EST,     COND_NONE,     STEP_IDLE);
      STEP_EMIT:    w = mk_uword(OP_EMIT,        COND_OUT_WAIT, STEP_IDLE);
      default:      w = mk_uword(OP_ACCEPT,      COND_IN_WAIT,  STEP_IDLE);
    endcase
    return w;
  endfunction

endpackage

>>> src/fm_tone_generator.sv
// Two-operator FM tone generator: microcoded sequencer over one shared multiplier
// and one registered sine ROM port. Depends on fmtg_pkg.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+---------------------------
//  in       | in_valid_i / in_stall_o  | note_code_i
//  out      | out_valid_o / out_stall_i| sample_o, is_rest_o
//  cfg      | cfg_we_i                 | cfg_idx_i, cfg_wdata_i
//
// A note runs the sequencer through steps 0..11, a rest only through IDLE, CARRIER and
// EMIT; the result is loaded into the output register at EMIT. Five products share one
// 32x32 multiplier and both sine lookups share one ROM read port.
// Reset clears the step and sample counters and loads the configuration defaults.
// A finished result waits in the output register while the next item is taken; the
// sequencer holds at its last step only while that register is full and stalled.
module fm_tone_generator #(
  parameter int unsigned SAMPLE_RATE    = fmtg_pkg::SAMPLE_RATE_DEF,
  parameter int unsigned SINE_ADDR_BITS = fmtg_pkg::SINE_ADDR_BITS_DEF,
  parameter int unsigned PHASE_BITS     = fmtg_pkg::PHASE_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [7:0]                           note_code_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [fmtg_pkg::SAMPLE_W-1:0] sample_o,
  output logic                                 is_rest_o,
  input  logic                                 cfg_we_i,
  input  logic [fmtg_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [fmtg_pkg::CFG_W-1:0]           cfg_wdata_i
);

  localparam int unsigned PB  = PHASE_BITS;
  localparam int unsigned SAB = SINE_ADDR_BITS;
  localparam int unsigned QTR = 1 << (SAB - 2);
  localparam int unsigned OFF_SHIFT = fmtg_pkg::TURN_Q - PB;
  localparam logic [63:0] ROUND_HALF = 64'd1 << (OFF_SHIFT - 1);
  localparam logic [63:0] RATE_Q16   = 64'(SAMPLE_RATE) << 16;
  localparam logic [SAB-2:0] QTR_IDX = (SAB-1)'(QTR);

  typedef logic [fmtg_pkg::NUM_OCT-1:0][fmtg_pkg::NUM_SEMI-1:0][PB-1:0] inc_tbl_t;
  typedef logic [QTR:0][fmtg_pkg::SINE_W-1:0] sine_tbl_t;

  function automatic inc_tbl_t build_inc();
    inc_tbl_t    t;
    logic [63:0] f;
    t = '0;
    for (int o = 0; o < fmtg_pkg::NUM_OCT; o++) begin
      for (int s = 0; s < fmtg_pkg::NUM_SEMI; s++) begin
        f       = 64'(fmtg_pkg::BASE_FREQ_Q16[s]) << o;
        t[o][s] = PB'((f << PB) / RATE_Q16);
      end
    end
    return t;
  endfunction

  function automatic sine_tbl_t build_sine();
    sine_tbl_t t;
    t = '0;
    for (int r = 0; r <= QTR; r++) begin
      t[r] = fmtg_pkg::quarter_sine(64'(r), SAB);
    end
    return t;
  endfunction

  localparam inc_tbl_t  INC_TBL  = build_inc();
  localparam sine_tbl_t SINE_TBL = build_sine();

  // Control
  logic [fmtg_pkg::STEP_W-1:0] step_q, step_d, step_inc;
  fmtg_pkg::uword_t            uw;
  logic                        in_xfer, out_free, emit;
  logic [PB-1:0]               cnt_q, cnt_d;
  logic                        out_valid_q, out_valid_d;

  // Configuration
  logic [fmtg_pkg::AMP_W-1:0]   amplitude_q;
  logic [fmtg_pkg::MIDX_W-1:0]  mod_index_q;
  logic [fmtg_pkg::RATIO_W-1:0] mod_ratio_q;

  // Datapath
  fmtg_pkg::note_t                     note;
  logic [PB-1:0]                       inc_q, carrier_q, ph_q, off;
  logic                                rest_q, rom_neg_q, msign_q;
  logic [fmtg_pkg::PROD_W-1:0]         prod_q, mul_p;
  logic [fmtg_pkg::MUL_W-1:0]          mul_a, mul_b;
  logic [SAB-1:0]                      rom_top;
  logic [1:0]                          rom_quad;
  logic [SAB-3:0]                      rom_r;
  logic [SAB-2:0]                      rom_idx;
  logic [fmtg_pkg::SINE_W-1:0]         rom_q;
  logic [fmtg_pkg::DIVP_W-1:0]         div_p;
  logic [fmtg_pkg::Q_W-1:0]            q_q, q_est, q_fix;
  logic [fmtg_pkg::REM_W-1:0]          rem;
  logic signed [fmtg_pkg::SAMPLE_W-1:0] samp_mag, samp_d, sample_q;
  logic                                is_rest_q;

  assign uw         = fmtg_pkg::ucode(step_q);
  assign in_stall_o = (uw.op != fmtg_pkg::OP_ACCEPT);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign emit       = (uw.op == fmtg_pkg::OP_EMIT) && out_free;
  assign note       = fmtg_pkg::decode_note(note_code_i);

  // Sequencer
  always_comb begin
    step_inc = step_q + fmtg_pkg::STEP_W'(1);
    unique case (uw.cond)
      fmtg_pkg::COND_NONE:     step_d = step_inc;
      fmtg_pkg::COND_IN_WAIT:  step_d = in_xfer ? step_inc : step_q;
      fmtg_pkg::COND_REST:     step_d = rest_q ? uw.target : step_inc;
      fmtg_pkg::COND_OUT_WAIT: step_d = out_free ? uw.target : step_q;
      default:                 step_d = fmtg_pkg::STEP_IDLE;
    endcase
  end

  assign cnt_d = emit ? cnt_q + PB'(1) : cnt_q;

  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= fmtg_pkg::STEP_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amplitude_q <= fmtg_pkg::AMP_RESET;
      mod_index_q <= fmtg_pkg::MIDX_RESET;
      mod_ratio_q <= fmtg_pkg::RATIO_RESET;
    end else if (cfg_we_i) begin
      unique case (fmtg_pkg::cfg_reg_e'(cfg_idx_i))
        fmtg_pkg::REG_AMPLITUDE: amplitude_q <= cfg_wdata_i[fmtg_pkg::AMP_W-1:0];
        fmtg_pkg::REG_MOD_INDEX: mod_index_q <= cfg_wdata_i[fmtg_pkg::MIDX_W-1:0];
        fmtg_pkg::REG_MOD_RATIO: mod_ratio_q <= cfg_wdata_i[fmtg_pkg::RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (uw.op)
      fmtg_pkg::OP_MUL_CARRIER: begin
        mul_a = fmtg_pkg::MUL_W'(cnt_q);
        mul_b = fmtg_pkg::MUL_W'(inc_q);
      end
      fmtg_pkg::OP_MUL_MOD: begin
        mul_a = fmtg_pkg::MUL_W'(prod_q[PB-1:0]);
        mul_b = fmtg_pkg::MUL_W'(mod_ratio_q);
      end
      fmtg_pkg::OP_MUL_IDX: begin
        mul_a = fmtg_pkg::MUL_W'(mod_index_q);
        mul_b = fmtg_pkg::MUL_W'(rom_q);
      end
      fmtg_pkg::OP_MUL_INV: begin
        mul_a = prod_q[fmtg_pkg::MUL_W-1:0];
        mul_b = fmtg_pkg::INV_TWO_PI_Q32;
      end
      fmtg_pkg::OP_MUL_AMP: begin
        mul_a = fmtg_pkg::MUL_W'(amplitude_q);
        mul_b = fmtg_pkg::MUL_W'(rom_q);
      end
      default: ;
    endcase
  end

  assign mul_p = fmtg_pkg::PROD_W'(mul_a) * fmtg_pkg::PROD_W'(mul_b);

  // Sine ROM addressing: fold the quarter wave, sign from the upper half
  assign rom_top  = (uw.op == fmtg_pkg::OP_ROM_MOD) ? prod_q[PB-1 -: SAB] : ph_q[PB-1 -: SAB];
  assign rom_quad = rom_top[SAB-1 -: 2];
  assign rom_r    = rom_top[SAB-3:0];
  assign rom_idx  = rom_quad[0] ? QTR_IDX - {1'b0, rom_r} : {1'b0, rom_r};

  // Offset and amplitude scaling
  assign off   = prod_q[PB-1:0];
  assign div_p = prod_q[fmtg_pkg::DIVP_W-1:0];
  // Divide by 32767: estimate from p + p/2^15, then one correction
  assign q_est = fmtg_pkg::Q_W'((fmtg_pkg::REM_W'(div_p)
                 + fmtg_pkg::REM_W'(div_p[fmtg_pkg::DIVP_W-1:fmtg_pkg::DIV_K_SHIFT]))
                 >> fmtg_pkg::DIV_K_SHIFT);
  assign rem   = fmtg_pkg::REM_W'(div_p) - {q_q, {fmtg_pkg::DIV_K_SHIFT{1'b0}}}
                 + fmtg_pkg::REM_W'(q_q);
  assign q_fix = (rem >= fmtg_pkg::REM_W'(fmtg_pkg::SINE_PEAK)) ? q_q + fmtg_pkg::Q_W'(1) : q_q;
  assign samp_mag = {1'b0, q_fix[fmtg_pkg::SINE_W-1:0]};

  always_comb begin
    if (rest_q) begin
      samp_d = '0;
    end else if (rom_neg_q) begin
      samp_d = -samp_mag;
    end else begin
      samp_d = samp_mag;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (uw.op)
      fmtg_pkg::OP_ACCEPT: begin
        if (in_xfer) begin
          inc_q  <= INC_TBL[note.oct][note.semi];
          rest_q <= note.rest;
        end
      end
      fmtg_pkg::OP_MUL_CARRIER: prod_q <= mul_p;
      fmtg_pkg::OP_MUL_MOD: begin
        carrier_q <= prod_q[PB-1:0];
        prod_q    <= mul_p;
      end
      fmtg_pkg::OP_ROM_MOD, fmtg_pkg::OP_ROM_TOT: begin
        rom_q     <= SINE_TBL[rom_idx];
        rom_neg_q <= rom_quad[1];
      end
      fmtg_pkg::OP_MUL_IDX: begin
        prod_q  <= mul_p;
        msign_q <= rom_neg_q;
      end
      fmtg_pkg::OP_MUL_INV: prod_q <= mul_p;
      fmtg_pkg::OP_ROUND:   prod_q <= (prod_q + ROUND_HALF) >> OFF_SHIFT;
      // Apply the modulator sign: subtract the rounded magnitude when negative, else add it
      fmtg_pkg::OP_ADD_OFF: ph_q <= msign_q ? carrier_q - off : carrier_q + off;
      fmtg_pkg::OP_MUL_AMP: prod_q <= mul_p;
      fmtg_pkg::OP_DIV_EST: q_q <= q_est;
      fmtg_pkg::OP_EMIT: begin
        if (out_free) begin
          sample_q  <= samp_d;
          is_rest_q <= rest_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;
  assign is_rest_o   = is_rest_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> step_q == fmtg_pkg::STEP_CARRIER)
    else $error("transfer did not start the step program");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= fmtg_pkg::STEP_LAST)
    else $error("step counter left the program");

  a_rest_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_rest_o |-> sample_o == '0)
    else $error("rest produced a nonzero sample");

  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_o && step_q == fmtg_pkg::STEP_IDLE)
    else $error("result not loaded into output register");

endmodule
